@@ src/cwc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller package
// Shared codes, constants and types of the congestion window controller.
// ----------------------------------------------------------------------------
package cwc_pkg;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THRESH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_STEP    = 1'b1;

  localparam logic [15:0] INIT_THRESH_RESET = 16'd32;
  localparam logic [16:0] ADD_STEP_RESET    = 17'd2048;

  // Window arithmetic in Q16.16 packets.
  localparam logic [31:0] ONE_PACKET  = 32'h0001_0000;
  localparam logic [31:0] TWO_PACKETS = 32'h0002_0000;
  localparam logic [1:0]  DUP_LIMIT   = 2'd3;

  localparam int unsigned MAX_OUTSTANDING_DEF = 256;

  // Depth of the queue between front and back; a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_ACK,
    OP_TIMEOUT,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] ack_number;
  } item_t;

  typedef enum logic {
    BK_IDLE,
    BK_GROW
  } back_state_e;

  typedef struct packed {
    logic        send_granted;
    logic [31:0] granted_seqno;
    logic        retransmit;
    logic [31:0] retransmit_from;
    logic [31:0] retransmit_to;
    logic [31:0] window_now;
    logic [31:0] threshold_now;
    logic        in_slow_start;
    logic [8:0]  acked_count;
  } res_t;

endpackage

@@ src/cwc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller channels
// Command channel and result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface cwc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] ack_number;

  modport source (output valid, command, ack_number, input ready);
  modport sink   (input valid, command, ack_number, output ready);
endinterface

interface cwc_res_if;
  logic        valid;
  logic        ready;
  logic        send_granted;
  logic [31:0] granted_seqno;
  logic        retransmit;
  logic [31:0] retransmit_from;
  logic [31:0] retransmit_to;
  logic [31:0] window_now;
  logic [31:0] threshold_now;
  logic        in_slow_start;
  logic [8:0]  acked_count;

  modport source (output valid, send_granted, granted_seqno, retransmit, retransmit_from,
                  retransmit_to, window_now, threshold_now, in_slow_start, acked_count,
                  input ready);
  modport sink   (input valid, send_granted, granted_seqno, retransmit, retransmit_from,
                  retransmit_to, window_now, threshold_now, in_slow_start, acked_count,
                  output ready);
endinterface

@@ src/cwc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller front end
// Accepts command items, decodes them into operations and pushes them into
// the queue towards the back end.
// ----------------------------------------------------------------------------
module cwc_front
  import cwc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cwc_cmd_if.sink    cmd_i,
  output logic       push_o,
  output item_t      push_item_o,
  input  logic       full_i
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;
  op_e   op_dec;

  always_comb begin
    unique case (cmd_i.command)
      CMD_SEND:    op_dec = OP_SEND;
      CMD_ACK:     op_dec = OP_ACK;
      CMD_TIMEOUT: op_dec = OP_TIMEOUT;
      default:     op_dec = OP_NOP;
    endcase
  end

  assign push_o      = valid_q && !full_i;
  assign push_item_o = item_q;
  assign cmd_i.ready = !valid_q || !full_i;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d           = 1'b1;
      item_d.op         = op_dec;
      item_d.ack_number = cmd_i.ack_number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ src/cwc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller queue
// Short first-in first-out queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module cwc_queue
  import cwc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t head_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // The front end never pushes into a full queue, so the fill never exceeds the depth.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || do_pop))
    else $error("queue pushed while full");

endmodule

@@ src/cwc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller back end
// Holds the window state, carries out sends, acks and timeouts, grows the
// window one acknowledged packet per cycle and registers the result.
// ----------------------------------------------------------------------------
module cwc_back
  import cwc_pkg::*;
#(
  parameter int unsigned MAX_OUTSTANDING = MAX_OUTSTANDING_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  item_valid_i,
  input  item_t                 item_i,
  output logic                  pop_o,
  cwc_res_if.source             res_o
);

  localparam int unsigned CntW = $clog2(MAX_OUTSTANDING + 1);

  back_state_e      state_q, state_d;
  logic [31:0]      window_q, window_d;
  logic [31:0]      thr_q, thr_d;
  logic             mode_q, mode_d;
  logic [31:0]      oldest_q, oldest_d;
  logic [31:0]      next_q, next_d;
  logic [31:0]      dup_val_q, dup_val_d;
  logic [1:0]       dup_cnt_q, dup_cnt_d;
  logic [16:0]      step_q, step_d;
  logic [CntW-1:0]  grow_cnt_q, grow_cnt_d;
  logic [CntW-1:0]  acked_q, acked_d;
  logic [31:0]      ack_q, ack_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  logic             slot_free;
  logic [31:0]      outs, outs_m1, ack_gap, take;
  logic             advance, is_advance, full, last_grow;
  logic [1:0]       dup_next;
  logic [32:0]      w_one, w_step, w_sum;
  logic             grow_mode;
  logic [31:0]      w_grown;
  logic [CntW+8:0]  acked_ext;

  assign slot_free = !res_valid_q || res_o.ready;
  assign pop_o     = (state_q == BK_IDLE) && item_valid_i && slot_free;

  // Classification of the head item against the current state.
  assign outs       = next_q - oldest_q;
  assign outs_m1    = outs - 32'd1;
  assign ack_gap    = item_i.ack_number - oldest_q;
  assign advance    = (outs != '0) && (ack_gap != '0) && !ack_gap[31];
  assign take       = (ack_gap < outs) ? ack_gap : outs;
  assign is_advance = (item_i.op == OP_ACK) && advance;
  assign full       = (outs >= 32'(MAX_OUTSTANDING)) ||
                      ((outs != '0) && ({outs_m1, 16'h0000} >= {16'h0000, window_q}));
  assign dup_next   = (item_i.ack_number == dup_val_q) ? (dup_cnt_q + 2'd1) : 2'd1;

  // One growth step: leave slow start once the next full packet would pass the threshold.
  assign w_one     = {1'b0, window_q} + {1'b0, ONE_PACKET};
  assign w_step    = {1'b0, window_q} + 33'(step_q);
  assign grow_mode = mode_q && !(w_one > {1'b0, thr_q});
  assign w_sum     = grow_mode ? w_one : w_step;
  assign w_grown   = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
  assign last_grow = (grow_cnt_q == CntW'(1));
  assign acked_ext = {9'h000, acked_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop_o && is_advance) begin
          state_d = BK_GROW;
        end
      end
      BK_GROW: begin
        if (last_grow) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and result register.
  always_comb begin
    window_d    = window_q;
    thr_d       = thr_q;
    mode_d      = mode_q;
    oldest_d    = oldest_q;
    next_d      = next_q;
    dup_val_d   = dup_val_q;
    dup_cnt_d   = dup_cnt_q;
    step_d      = step_q;
    grow_cnt_d  = grow_cnt_q;
    acked_d     = acked_q;
    ack_d       = ack_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_d       = res_q;

    if (state_q == BK_GROW) begin
      window_d   = w_grown;
      mode_d     = grow_mode;
      grow_cnt_d = grow_cnt_q - CntW'(1);
      if (last_grow) begin
        oldest_d              = oldest_q + 32'(acked_q);
        dup_val_d             = ack_q;
        dup_cnt_d             = 2'd0;
        res_valid_d           = 1'b1;
        res_d                 = '0;
        res_d.window_now      = w_grown;
        res_d.threshold_now   = thr_q;
        res_d.in_slow_start   = grow_mode;
        res_d.acked_count     = acked_ext[8:0];
      end
    end else if (pop_o) begin
      res_d = '0;
      case (item_i.op)
        OP_SEND: begin
          if (!full) begin
            res_d.send_granted  = 1'b1;
            res_d.granted_seqno = next_q;
            next_d              = next_q + 32'd1;
          end
        end
        OP_ACK: begin
          if (advance) begin
            grow_cnt_d = take[CntW-1:0];
            acked_d    = take[CntW-1:0];
            ack_d      = item_i.ack_number;
          end else if (outs != '0) begin
            dup_val_d = item_i.ack_number;
            dup_cnt_d = dup_next;
            if (dup_next == DUP_LIMIT) begin
              dup_cnt_d = 2'd0;
              if (window_q >= TWO_PACKETS) begin
                window_d = window_q >> 1;
                thr_d    = window_q >> 1;
              end
              mode_d                = 1'b0;
              res_d.retransmit      = 1'b1;
              res_d.retransmit_from = oldest_q;
              res_d.retransmit_to   = next_q - 32'd1;
            end
          end
        end
        OP_TIMEOUT: begin
          if (outs != '0) begin
            if (thr_q >= TWO_PACKETS) begin
              thr_d = window_q >> 1;
            end
            window_d              = ONE_PACKET;
            mode_d                = 1'b1;
            res_d.retransmit      = 1'b1;
            res_d.retransmit_from = oldest_q;
            res_d.retransmit_to   = next_q - 32'd1;
          end
        end
        default: begin
        end
      endcase
      // An advancing ack reports only after its growth steps.
      if (!is_advance) begin
        res_valid_d         = 1'b1;
        res_d.window_now    = window_d;
        res_d.threshold_now = thr_d;
        res_d.in_slow_start = mode_d;
      end
    end

    // The user must write configuration only while no item is in flight; the block itself does not enforce this.
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_INIT_THRESH) begin
        thr_d = {cfg_data_i[15:0], 16'h0000};
      end else if (cfg_idx_i == REG_ADD_STEP) begin
        step_d = cfg_data_i[16:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      window_q    <= ONE_PACKET;
      thr_q       <= {INIT_THRESH_RESET, 16'h0000};
      mode_q      <= 1'b1;
      oldest_q    <= 32'd1;
      next_q      <= 32'd1;
      dup_val_q   <= '0;
      dup_cnt_q   <= '0;
      step_q      <= ADD_STEP_RESET;
      grow_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      thr_q       <= thr_d;
      mode_q      <= mode_d;
      oldest_q    <= oldest_d;
      next_q      <= next_d;
      dup_val_q   <= dup_val_d;
      dup_cnt_q   <= dup_cnt_d;
      step_q      <= step_d;
      grow_cnt_q  <= grow_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acked_q <= acked_d;
    ack_q   <= ack_d;
    res_q   <= res_d;
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.send_granted    = res_q.send_granted;
  assign res_o.granted_seqno   = res_q.granted_seqno;
  assign res_o.retransmit      = res_q.retransmit;
  assign res_o.retransmit_from = res_q.retransmit_from;
  assign res_o.retransmit_to   = res_q.retransmit_to;
  assign res_o.window_now      = res_q.window_now;
  assign res_o.threshold_now   = res_q.threshold_now;
  assign res_o.in_slow_start   = res_q.in_slow_start;
  assign res_o.acked_count     = res_q.acked_count;

  a_grow_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_GROW) |-> (grow_cnt_q != '0))
    else $error("growth loop running with no packets left");

  a_window_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_q >= ONE_PACKET)
    else $error("window fell below one packet");

  a_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_q - oldest_q) <= 32'(MAX_OUTSTANDING))
    else $error("more packets outstanding than allowed");

endmodule

@@ src/congestion_window_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller
// Sender-side window control: grants sends, grows the window on acks, reacts
// to the third duplicate ack and to timeouts with a retransmit range.
// ----------------------------------------------------------------------------
// Path: a send, timeout or non-advancing ack passes the front register, the
//   queue and the result register; an advancing ack adds a growth step per packet.
// Throughput: one item per cycle for single-step items while results are taken;
//   an advancing ack holds the back end for its growth steps (one-step adder).
// Reset: asynchronous, active low; window one packet, threshold 32 packets,
//   slow start, sequence numbers at one, queue and result register empty.
// ----------------------------------------------------------------------------
module congestion_window_controller
  import cwc_pkg::*;
#(
  parameter int unsigned MAX_OUTSTANDING = MAX_OUTSTANDING_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cwc_cmd_if.sink               cmd_i,
  cwc_res_if.source             res_o
);

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  item_t q_head;
  logic  pop;

  cwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (q_full)
  );

  cwc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (pop)
  );

  cwc_back #(
    .MAX_OUTSTANDING (MAX_OUTSTANDING)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (q_valid),
    .item_i       (q_head),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule

@@ verif/congestion_window_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller testbench
// Drives send, ack and timeout items into the controller and checks every
// result item against a cycle-free predictor of the window, the threshold,
// the mode and the sequence space. Covers the corner events, random
// traffic under three idling patterns, a long receiver stall and rounds of
// filling and acknowledging the window that make it grow.
// ----------------------------------------------------------------------------
module congestion_window_controller_tb;
  import cwc_pkg::*;

  localparam int unsigned MAX_OUT      = MAX_OUTSTANDING_DEF;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam int unsigned PHASE_ITEMS  = 300;
  localparam int unsigned GROWTH_ITEMS = 96;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cwc_cmd_if cmd_if ();
  cwc_res_if res_if ();

  congestion_window_controller #(
    .MAX_OUTSTANDING(MAX_OUT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  // Predictor state: configuration, window, threshold and sequence space.
  logic [16:0] add_step;
  logic [31:0] cwnd;
  logic [31:0] ssthresh;
  logic        in_ss;
  logic [31:0] snd_una;
  logic [31:0] snd_nxt;
  logic [31:0] dup_seq;
  logic [1:0]  dup_hits;

  res_t        pending_results[$];
  res_t        last_result;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  bit          stall_req     = 1'b0;
  bit          stall_seen    = 1'b0;
  int unsigned stall_left    = 0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("congestion_window_controller test failed");
      $finish;
    end
  end

  function automatic void grow_cwnd();
    logic [32:0] w;
    w = {1'b0, cwnd};
    if (w + 33'(ONE_PACKET) > 33'(ssthresh)) in_ss = 1'b0;
    w = w + (in_ss ? 33'(ONE_PACKET) : 33'(add_step));
    cwnd = w[32] ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic res_t step_window(op_e op, logic [31:0] ack);
    res_t        r;
    logic [31:0] in_flight;
    logic [31:0] ack_gap;
    logic [8:0]  newly;
    r = '0;
    in_flight = snd_nxt - snd_una;
    case (op)
      OP_SEND: begin
        if (in_flight < MAX_OUT &&
            (in_flight == 0 || (48'(in_flight - 32'd1) << 16) < 48'(cwnd))) begin
          r.send_granted  = 1'b1;
          r.granted_seqno = snd_nxt;
          snd_nxt         = snd_nxt + 32'd1;
        end
      end
      OP_ACK: if (in_flight != 0) begin
        ack_gap = ack - snd_una;
        // An ack advances only when it lies in the forward half of the space.
        if (ack_gap != 0 && !ack_gap[31]) begin
          newly = (ack_gap < in_flight) ? ack_gap[8:0] : in_flight[8:0];
          for (int i = 0; i < newly; i++) grow_cwnd();
          snd_una       = snd_una + 32'(newly);
          dup_seq       = ack;
          dup_hits      = '0;
          r.acked_count = newly;
        end else begin
          if (ack == dup_seq) begin
            dup_hits = dup_hits + 2'd1;
          end else begin
            dup_seq  = ack;
            dup_hits = 2'd1;
          end
          if (dup_hits == DUP_LIMIT) begin
            dup_hits = '0;
            if (cwnd >= TWO_PACKETS) begin
              cwnd     = cwnd >> 1;
              ssthresh = cwnd;
            end
            in_ss             = 1'b0;
            r.retransmit      = 1'b1;
            r.retransmit_from = snd_una;
            r.retransmit_to   = snd_nxt - 32'd1;
          end
        end
      end
      OP_TIMEOUT: if (in_flight != 0) begin
        if (ssthresh >= TWO_PACKETS) ssthresh = cwnd >> 1;
        cwnd              = ONE_PACKET;
        in_ss             = 1'b1;
        r.retransmit      = 1'b1;
        r.retransmit_from = snd_una;
        r.retransmit_to   = snd_nxt - 32'd1;
      end
      default: ;
    endcase
    r.window_now    = cwnd;
    r.threshold_now = ssthresh;
    r.in_slow_start = in_ss;
    return r;
  endfunction

  // The valid is left high after acceptance; the next call either reuses it
  // or lowers it, so it never sees two assignments in one step.
  task automatic send_item(input op_e op, input logic [31:0] ack);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= op;
    cmd_if.ack_number <= ack;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    last_result = step_window(op, ack);
    pending_results.push_back(last_result);
    items_sent++;
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_INIT_THRESH: begin
        ssthresh = {data[15:0], 16'h0000};
      end
      REG_ADD_STEP: add_step = data;
      default: ;
    endcase
  endtask

  // One step of sender traffic: mostly sends and in-range acks, with bursts
  // of repeated acks, timeouts and some noise.
  task automatic random_event();
    logic [31:0] in_flight;
    logic [31:0] dup;
    int unsigned pick;
    in_flight = snd_nxt - snd_una;
    pick = $urandom_range(99);
    if (pick < 45 || (in_flight == 0 && pick < 90)) begin
      send_item(OP_SEND, $urandom());
    end else if (pick < 72) begin
      send_item(OP_ACK, snd_una + $urandom_range(1, in_flight + 2));
    end else if (pick < 84) begin
      dup = ($urandom_range(3) == 0) ? snd_una - $urandom_range(1, 1000) : snd_una;
      repeat ($urandom_range(1, 4)) send_item(OP_ACK, dup);
    end else if (pick < 90) begin
      send_item(OP_TIMEOUT, $urandom());
    end else if (pick < 96) begin
      send_item(OP_ACK, $urandom());
    end else begin
      send_item(op_e'($urandom_range(3)), $urandom());
    end
  endtask

  task automatic test_directed_events();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Nothing outstanding: ack and timeout change nothing, nor does a no-op.
    send_item(OP_ACK, 32'd5);
    send_item(OP_TIMEOUT, 32'd0);
    send_item(OP_NOP, 32'hFFFF_FFFF);
    send_item(OP_SEND, 32'h0000_0000);
    send_item(OP_SEND, 32'hFFFF_FFFF);
    send_item(OP_SEND, 32'h5555_AAAA);
    // Third duplicate while the window is below two packets.
    repeat (3) send_item(OP_ACK, snd_una);
    send_item(OP_ACK, snd_una + 32'h8000_0000);
    send_item(OP_ACK, snd_una + 32'h7FFF_FFFF);
    send_item(OP_ACK, 32'h0000_0000);
    repeat (3) send_item(OP_SEND, $urandom());
    send_item(OP_TIMEOUT, $urandom());
    send_item(OP_ACK, snd_una + 32'd1);
    send_item(OP_ACK, snd_nxt);
    settle();
  endtask

  task automatic test_traffic_phase(input int unsigned tx_idle, input int unsigned rx_idle,
                                    input logic [15:0] thr, input logic [16:0] step,
                                    input int unsigned count);
    int unsigned first;
    write_reg(REG_INIT_THRESH, {1'b0, thr});
    write_reg(REG_ADD_STEP, step);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    first = items_sent;
    while (items_sent - first < count) random_event();
    settle();
  endtask

  // The receiver holds off while the sender keeps offering items, so the
  // block fills up and has to stall its input.
  task automatic test_receiver_stall();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    stall_req = ~stall_req;
    repeat (60) random_event();
    settle();
  endtask

  task automatic test_window_growth();
    int unsigned first;
    write_reg(REG_INIT_THRESH, 17'h0_FFFF);
    write_reg(REG_ADD_STEP, 17'h1_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    first = items_sent;
    // Fill the window, then acknowledge everything, round after round.
    while (items_sent - first < GROWTH_ITEMS) begin
      do send_item(OP_SEND, $urandom()); while (last_result.send_granted);
      send_item(OP_ACK, snd_nxt);
    end
    repeat (3) send_item(OP_SEND, $urandom());
    repeat (3) send_item(OP_ACK, snd_una);
    send_item(OP_TIMEOUT, $urandom());
    settle();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = STALL_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result item with none expected, expected nothing, got window %0h",
                   $time, res_if.window_now);
      end else begin
        want = pending_results.pop_front();
        check_field("send_granted", 32'(want.send_granted), 32'(res_if.send_granted));
        check_field("granted_seqno", want.granted_seqno, res_if.granted_seqno);
        check_field("retransmit", 32'(want.retransmit), 32'(res_if.retransmit));
        check_field("retransmit_from", want.retransmit_from, res_if.retransmit_from);
        check_field("retransmit_to", want.retransmit_to, res_if.retransmit_to);
        check_field("window_now", want.window_now, res_if.window_now);
        check_field("threshold_now", want.threshold_now, res_if.threshold_now);
        check_field("in_slow_start", 32'(want.in_slow_start), 32'(res_if.in_slow_start));
        check_field("acked_count", 32'(want.acked_count), 32'(res_if.acked_count));
      end
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = '0;
    cmd_if.ack_number = '0;
    res_if.ready      = 1'b0;
    add_step          = ADD_STEP_RESET;
    cwnd              = ONE_PACKET;
    ssthresh          = {INIT_THRESH_RESET, 16'h0000};
    in_ss             = 1'b1;
    snd_una           = 32'd1;
    snd_nxt           = 32'd1;
    dup_seq           = '0;
    dup_hits          = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_events();
    test_traffic_phase(33, 77, 16'($urandom_range(2, 64)), 17'($urandom_range(1, 65536)),
                       PHASE_ITEMS);
    test_receiver_stall();
    test_traffic_phase(77, 33, 16'd1, 17'd1, PHASE_ITEMS);
    test_traffic_phase(0, 0, 16'hFFFF, 17'h1_0000, PHASE_ITEMS);
    test_window_growth();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("congestion_window_controller test passed");
    end else begin
      $display("congestion_window_controller test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cwc_pkg.sv
src/cwc_if.sv
src/cwc_front.sv
src/cwc_queue.sv
src/cwc_back.sv
src/congestion_window_controller.sv
verif/congestion_window_controller_tb.sv
